// ===== rtl/core/fnv1a64_base36_suffix_unit_assert.svh =====
// Assertion macros for the FNV-1a base-36 suffix unit.
// Expects a clock named clk and a reset named rst in the using module.
`ifndef FNV1A64_BASE36_SUFFIX_UNIT_ASSERT_SVH
`define FNV1A64_BASE36_SUFFIX_UNIT_ASSERT_SVH
// same-cycle implication
`define FNVB36_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fnvb36 assertion failed");
// next-cycle implication
`define FNVB36_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fnvb36 assertion failed");
`endif

// ===== rtl/core/fnvb36_pkg.sv =====
// Shared types, constants and functions of the FNV-1a base-36 suffix unit.
// No dependencies.
`default_nettype none
package fnvb36_pkg;

  localparam int HASH_W          = 64;
  localparam int NUM_FIELDS      = 5;
  localparam int CHAR_W          = 7;
  localparam int SUFFIX_DIGITS_D = 5;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;

  // long division by 36, one chunk of the hash a cycle, most significant first
  localparam int RADIX      = 36;
  localparam int REM_W      = 6;
  localparam int CHUNK_W    = 16;
  localparam int NUM_CHUNKS = HASH_W / CHUNK_W;
  localparam int PART_W     = REM_W + CHUNK_W;
  localparam int RECIP_S    = 27;
  localparam logic [PART_W-1:0] RECIP_M = 22'd3728271;

  typedef logic [HASH_W-1:0] hash_t;

  typedef struct packed {
    logic  valid;
    hash_t hash;
  } hash_req_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } queue_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_HOLD
  } back_state_t;

  // multiply by the FNV prime 2^40 + 2^8 + 0xb3, low 64 bits
  function automatic hash_t fnv_mul(input hash_t x);
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [REM_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    return (d < 6'd10) ? (7'd48 + dx) : (7'd87 + dx);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fnvb36_front.sv =====
// Front: takes string bytes and keeps the running FNV-1a hash.
// Pushes the final hash of each string into the queue. Uses fnvb36_pkg.
`default_nettype none
module fnvb36_front (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     byte_valid,
  output logic                    byte_stall,
  input  wire  [7:0]              data_byte,
  input  wire                     end_of_string,
  input  fnvb36_pkg::queue_stat_t q_stat,
  output fnvb36_pkg::hash_req_t   push
);
  import fnvb36_pkg::*;

  hash_t running_hash;
  hash_t hash_next;
  logic  take;

  assign byte_stall = q_stat.full;
  assign take       = byte_valid && !q_stat.full;
  assign hash_next  = fnv_mul(running_hash ^ {56'd0, data_byte});

  assign push.valid = take && end_of_string;
  assign push.hash  = hash_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= FNV_BASIS;
    end else if (take) begin
      running_hash <= end_of_string ? FNV_BASIS : hash_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/fnvb36_queue.sv =====
// Short queue of finished hashes between front and back.
// Uses fnvb36_pkg.
`default_nettype none
module fnvb36_queue (
  input  wire                     clk,
  input  wire                     rst,
  input  fnvb36_pkg::hash_req_t   push,
  input  wire                     pop,
  output fnvb36_pkg::hash_t       head,
  output fnvb36_pkg::queue_stat_t q_stat
);
  import fnvb36_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  hash_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign q_stat.full     = (count == CNT_W'(QUEUE_DEPTH));
  assign q_stat.nonempty = (count != '0);
  assign head            = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.hash;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push.valid && !pop) begin
        count <= count + 1'b1;
      end else if (!push.valid && pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/fnvb36_back.sv =====
// Back: converts each queued hash to base-36 characters by chunked division
// by 36, and holds the result in the output register. Uses fnvb36_pkg.
`default_nettype none
module fnvb36_back #(
  parameter int SUFFIX_DIGITS = fnvb36_pkg::SUFFIX_DIGITS_D
) (
  input  wire                     clk,
  input  wire                     rst,
  input  fnvb36_pkg::queue_stat_t q_stat,
  input  fnvb36_pkg::hash_t       head,
  output logic                    pop,
  output logic                    result_valid,
  input  wire                     result_stall,
  output logic [fnvb36_pkg::NUM_FIELDS-1:0][fnvb36_pkg::CHAR_W-1:0] digits
);
  import fnvb36_pkg::*;

  localparam int DCW   = $clog2(SUFFIX_DIGITS + 1);
  localparam int CHW   = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int PROD_W = 2 * PART_W;

  back_state_t st;
  back_state_t st_next;

  hash_t                              work;
  logic [REM_W-1:0]                   rem;
  logic [CHW-1:0]                     chunk;
  logic [DCW-1:0]                     dcnt;
  logic [NUM_FIELDS-1:0][CHAR_W-1:0]  digit_reg;

  logic               conv;
  logic               load;
  logic               last_chunk;
  logic               last_digit;
  logic [PART_W-1:0]  part;
  logic [PROD_W-1:0]  prod;
  logic [CHUNK_W-1:0] q;
  logic [PART_W-1:0]  qx;
  logic [PART_W-1:0]  r_full;
  logic [REM_W-1:0]   r;

  assign last_chunk = (chunk == CHW'(NUM_CHUNKS - 1));
  assign last_digit = (dcnt == DCW'(SUFFIX_DIGITS - 1));

  assign part   = {rem, work[HASH_W-1 -: CHUNK_W]};
  assign prod   = {{PART_W{1'b0}}, part} * {{PART_W{1'b0}}, RECIP_M};
  assign q      = prod[RECIP_S +: CHUNK_W];
  assign qx     = {{REM_W{1'b0}}, q};
  assign r_full = part - (qx << 5) - (qx << 2);
  assign r      = r_full[REM_W-1:0];

  always_comb begin
    st_next = st;
    unique case (st)
      BK_IDLE: begin
        if (q_stat.nonempty) st_next = BK_CONV;
      end
      BK_CONV: begin
        if (last_chunk && last_digit) st_next = BK_HOLD;
      end
      BK_HOLD: begin
        if (!result_valid || !result_stall) st_next = BK_IDLE;
      end
      default: st_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    conv = 1'b0;
    load = 1'b0;
    unique case (st)
      BK_IDLE: pop  = q_stat.nonempty;
      BK_CONV: conv = 1'b1;
      BK_HOLD: load = !result_valid || !result_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= BK_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work  <= head;
      rem   <= '0;
      chunk <= '0;
      dcnt  <= '0;
    end else if (conv) begin
      work <= {work[HASH_W-CHUNK_W-1:0], q};
      if (last_chunk) begin
        rem   <= '0;
        chunk <= '0;
        dcnt  <= dcnt + 1'b1;
      end else begin
        rem   <= r;
        chunk <= chunk + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_FIELDS; j++) begin
      if (j < SUFFIX_DIGITS && conv && last_chunk && dcnt == DCW'(j)) begin
        digit_reg[j] <= digit_char(r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int j = 0; j < NUM_FIELDS; j++) begin
        digits[j] <= (j < SUFFIX_DIGITS) ? digit_reg[j] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

`include "fnv1a64_base36_suffix_unit_assert.svh"

  `FNVB36_ASSERT_NOW(a_rem_range, st == BK_CONV, rem < 6'd36)
  `FNVB36_ASSERT_NOW(a_pop_idle, pop, st == BK_IDLE && q_stat.nonempty)
  `FNVB36_ASSERT_NOW(a_load_free, load, !result_valid || !result_stall)
  `FNVB36_ASSERT_NEXT(a_conv_done, conv && last_chunk && last_digit, st == BK_HOLD)

endmodule
`default_nettype wire

// ===== rtl/core/fnv1a64_base36_suffix_unit.sv =====
// FNV-1a 64-bit hash of a byte string, reported as base-36 characters.
// Input channel: byte_valid / byte_stall with data_byte and end_of_string.
//   One byte is taken per cycle while byte_stall is low; the hash update
//   is a combinational constant multiply, so bytes stream back to back.
// Output channel: result_valid / result_stall with digit_0..digit_4, the
//   ASCII characters of the hash in base 36, least significant first;
//   fields beyond SUFFIX_DIGITS read as zero.
// Conversion runs one 16-bit chunk of division by 36 per cycle, and the
//   back end takes a new hash from the queue only once the last result is
//   loaded into the output register; a two-entry queue of finished hashes
//   lets bytes keep flowing meanwhile.
// byte_stall rises only when that queue is full.
// While result_stall is high the result holds; the back end completes the
//   next conversion and waits for the output register to free.
// Reset (rst, synchronous) returns the hash to the offset basis, empties
//   the queue and drops result_valid.
`default_nettype none
module fnv1a64_base36_suffix_unit #(
  parameter int SUFFIX_DIGITS = fnvb36_pkg::SUFFIX_DIGITS_D
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        byte_valid,
  output logic       byte_stall,
  input  wire  [7:0] data_byte,
  input  wire        end_of_string,
  output logic       result_valid,
  input  wire        result_stall,
  output logic [6:0] digit_0,
  output logic [6:0] digit_1,
  output logic [6:0] digit_2,
  output logic [6:0] digit_3,
  output logic [6:0] digit_4
);
  import fnvb36_pkg::*;

  hash_req_t                         push;
  queue_stat_t                       q_stat;
  hash_t                             head;
  logic                              pop;
  logic [NUM_FIELDS-1:0][CHAR_W-1:0] digits;

  fnvb36_front u_front (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .q_stat        (q_stat),
    .push          (push)
  );

  fnvb36_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  fnvb36_back #(
    .SUFFIX_DIGITS (SUFFIX_DIGITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .digits       (digits)
  );

  assign digit_0 = digits[0];
  assign digit_1 = digits[1];
  assign digit_2 = digits[2];
  assign digit_3 = digits[3];
  assign digit_4 = digits[4];

endmodule
`default_nettype wire

// ===== verif/fnv1a64_base36_suffix_unit_tb.sv =====
// Testbench for fnv1a64_base36_suffix_unit: streams byte strings, tracks FNV-1a hashes
// in a scoreboard class and checks every base-36 suffix against the prediction.
// Depends on fnvb36_pkg and the unit itself.
`timescale 1ns / 1ps

module fnv1a64_base36_suffix_unit_tb;
  import fnvb36_pkg::*;

  localparam int N_DIGITS = SUFFIX_DIGITS_D;
  localparam logic [HASH_W-1:0] FNV_PRIME = 64'd1099511628211;
  localparam int SETTLE = 4 * N_DIGITS + 10;

  typedef logic [NUM_FIELDS-1:0][CHAR_W-1:0] suffix_t;

  class suffix_tracker;
    hash_t       hash_acc;
    suffix_t     pending[$];
    int unsigned mismatches;

    function new();
      hash_acc   = FNV_BASIS;
      mismatches = 0;
    endfunction

    // fold one accepted request into the hash; queue a suffix on the last byte
    function void absorb_byte(logic [7:0] b, logic last);
      suffix_t    s;
      hash_t      h;
      logic [5:0] rem;
      hash_acc = (hash_acc ^ {56'd0, b}) * FNV_PRIME;
      if (last) begin
        h = hash_acc;
        s = '0;
        for (int j = 0; j < NUM_FIELDS; j++) begin
          if (j < N_DIGITS) begin
            rem  = 6'(h % 64'(RADIX));
            s[j] = (rem < 6'd10) ? (7'd48 + {1'b0, rem}) : (7'd87 + {1'b0, rem});
            h    = h / 64'(RADIX);
          end
        end
        pending.insert(pending.size(), s);
        hash_acc = FNV_BASIS;
      end
    endfunction

    function void compare_suffix(suffix_t got);
      suffix_t want;
      if (pending.size() == 0) begin
        $error("result with no string outstanding: %h", got);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      for (int j = 0; j < NUM_FIELDS; j++) begin
        if (got[j] !== want[j]) begin
          $error("digit_%0d: expected %0d, actual %0d", j, want[j], got[j]);
          mismatches++;
        end
      end
    endfunction

    function int outstanding();
      return pending.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  logic [7:0] data_byte = 8'd0;
  logic       end_of_string = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [6:0] digit_0, digit_1, digit_2, digit_3, digit_4;

  suffix_tracker tracker = new();
  int            stall_left = 0;
  int            stall_pick;
  int            bytes_sent = 0;

  fnv1a64_base36_suffix_unit #(
    .SUFFIX_DIGITS(N_DIGITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .end_of_string(end_of_string),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .digit_0      (digit_0),
    .digit_1      (digit_1),
    .digit_2      (digit_2),
    .digit_3      (digit_3),
    .digit_4      (digit_4)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      tracker.compare_suffix({digit_4, digit_3, digit_2, digit_1, digit_0});
    end
  end

  // output back-pressure: long free stretches, short blips, the odd long hold
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 55) begin
        result_stall <= 1'b0;
        stall_left = $urandom_range(5, 60);
      end else if (stall_pick < 90) begin
        result_stall <= 1'b1;
        stall_left = $urandom_range(1, 3);
      end else begin
        result_stall <= 1'b1;
        stall_left = $urandom_range(10, 40);
      end
    end else begin
      stall_left--;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    byte_valid    <= 1'b1;
    data_byte     <= b;
    end_of_string <= last;
    do @(posedge clk); while (byte_stall);
    tracker.absorb_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      byte_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_string(input int len, input bit dense, input bit printable);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if (!dense) pause(draw_gap());
      b = printable ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255));
      send_byte(b, i == len - 1);
    end
  endtask

  initial begin
    int len;
    int r;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single-byte strings at the byte extremes and 0x61, then a four-byte string
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h61, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    // back-to-back one-byte strings to fill the hash queue
    send_byte(8'h55, 1'b1);
    send_byte(8'haa, 1'b1);
    send_byte(8'h7f, 1'b1);
    send_byte(8'hfe, 1'b1);
    send_byte(8'h01, 1'b1);
    // long run of 0xff, last mark on the tenth byte only, hash wraps many times
    for (int i = 0; i < 10; i++) send_byte(8'hff, i == 9);

    while (bytes_sent < 800) begin
      r = $urandom_range(0, 99);
      if (r < 40) len = 1;
      else if (r < 85) len = $urandom_range(2, 12);
      else len = $urandom_range(13, 64);
      send_string(len, $urandom_range(0, 9) < 3, 1'($urandom_range(0, 1)));
    end
    byte_valid <= 1'b0;

    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("fnv1a64_base36_suffix_unit_tb: clean");
    end else begin
      $display("fnv1a64_base36_suffix_unit_tb: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("fnv1a64_base36_suffix_unit_tb: errors");
    $finish;
  end

endmodule
